[rtl/vector_distance_metric_defines.svh]
// ----------------------------------------------------------------------------
// Vector distance metric assertion macros
// Shared assertion forms used by the top level of the distance block.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_METRIC_DEFINES_SVH
`define VECTOR_DISTANCE_METRIC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vdm_pkg.sv]
// ----------------------------------------------------------------------------
// Vector distance metric package
// Widths, metric codes and state types shared by the distance block.
// ----------------------------------------------------------------------------
package vdm_pkg;

    localparam int ACC_W    = 48;
    localparam int IN_W     = 16;
    localparam int Q_W      = 31;
    localparam int DIGIT_W  = 16;
    localparam int PROD_W   = 2 * ACC_W;
    localparam int SRCH_W   = 157;
    localparam int FRAC_W   = 30;
    localparam int BIT_W    = 5;

    localparam logic [1:0] METRIC_L2  = 2'd0;
    localparam logic [1:0] METRIC_COS = 2'd1;
    localparam logic [1:0] METRIC_DOT = 2'd2;

    localparam logic [ACC_W-1:0] Q_ONE = ACC_W'(64'h4000_0000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FINAL,
        ST_COS
    } top_state_t;

    typedef enum logic [2:0] {
        COS_IDLE,
        COS_MUL_P,
        COS_MUL_D,
        COS_CHECK,
        COS_SEARCH,
        COS_DONE
    } cos_state_t;

endpackage

[rtl/vdm_lane.sv]
// ----------------------------------------------------------------------------
// Vector distance metric lane
// Forms the dot, norm and squared difference products of one element pair.
// ----------------------------------------------------------------------------
module vdm_lane
    import vdm_pkg::*;
#(
    parameter int ELEM_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        take,
    input  logic [IN_W-1:0]             a_in,
    input  logic [IN_W-1:0]             b_in,
    output logic signed [2*ELEM_BITS+2:0] dot_reg,
    output logic signed [2*ELEM_BITS+2:0] aa_reg,
    output logic signed [2*ELEM_BITS+2:0] bb_reg,
    output logic signed [2*ELEM_BITS+2:0] dd_reg
);

    localparam int PW = 2 * ELEM_BITS + 3;

    logic signed [ELEM_BITS-1:0] a_s;
    logic signed [ELEM_BITS-1:0] b_s;
    logic signed [ELEM_BITS:0]   df;
    logic signed [PW-1:0]        dot_next;
    logic signed [PW-1:0]        aa_next;
    logic signed [PW-1:0]        bb_next;
    logic signed [PW-1:0]        dd_next;

    assign a_s      = a_in[ELEM_BITS-1:0];
    assign b_s      = b_in[ELEM_BITS-1:0];
    assign df       = a_s - b_s;
    assign dot_next = a_s * b_s;
    assign aa_next  = a_s * a_s;
    assign bb_next  = b_s * b_s;
    assign dd_next  = df * df;

    always_ff @(posedge aclk) begin
        if (load) begin
            dot_reg <= take ? dot_next : '0;
            aa_reg  <= take ? aa_next  : '0;
            bb_reg  <= take ? bb_next  : '0;
            dd_reg  <= take ? dd_next  : '0;
        end
    end

endmodule

[rtl/vdm_merge.sv]
// ----------------------------------------------------------------------------
// Vector distance metric merge stage
// Adds the lane products into the four wrapping 48-bit accumulators.
// ----------------------------------------------------------------------------
module vdm_merge
    import vdm_pkg::*;
#(
    parameter int LANES = 4,
    parameter int PW    = 35
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    valid,
    input  logic                    clear,
    input  logic signed [PW-1:0]    dot_in [LANES],
    input  logic signed [PW-1:0]    aa_in  [LANES],
    input  logic signed [PW-1:0]    bb_in  [LANES],
    input  logic signed [PW-1:0]    dd_in  [LANES],
    output logic [ACC_W-1:0]        dot_reg,
    output logic [ACC_W-1:0]        norm_a_reg,
    output logic [ACC_W-1:0]        norm_b_reg,
    output logic [ACC_W-1:0]        sqdiff_reg
);

    logic [ACC_W-1:0] dot_sum;
    logic [ACC_W-1:0] aa_sum;
    logic [ACC_W-1:0] bb_sum;
    logic [ACC_W-1:0] dd_sum;

    always_comb begin
        dot_sum = '0;
        aa_sum  = '0;
        bb_sum  = '0;
        dd_sum  = '0;
        for (int i = 0; i < LANES; i++) begin
            dot_sum = dot_sum + ACC_W'(dot_in[i]);
            aa_sum  = aa_sum  + ACC_W'(aa_in[i]);
            bb_sum  = bb_sum  + ACC_W'(bb_in[i]);
            dd_sum  = dd_sum  + ACC_W'(dd_in[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
            sqdiff_reg <= '0;
        end else if (valid) begin
            dot_reg    <= dot_reg    + dot_sum;
            norm_a_reg <= norm_a_reg + aa_sum;
            norm_b_reg <= norm_b_reg + bb_sum;
            sqdiff_reg <= sqdiff_reg + dd_sum;
        end
    end

endmodule

[rtl/vdm_cosine.sv]
// ----------------------------------------------------------------------------
// Vector distance metric cosine unit
// Finds the largest q up to 2^30 with q*q*na*nb <= d*d*2^60, one bit a cycle.
// ----------------------------------------------------------------------------
module vdm_cosine
    import vdm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ACC_W-1:0]   dot_mag,
    input  logic [ACC_W-1:0]   norm_a,
    input  logic [ACC_W-1:0]   norm_b,
    output logic               done,
    output logic [Q_W-1:0]     q_out
);

    cos_state_t          state_reg, state_next;
    logic [ACC_W-1:0]    x_reg, x_next;
    logic [ACC_W-1:0]    y_reg, y_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [1:0]          dig_reg, dig_next;
    logic [SRCH_W-1:0]   s_reg, s_next;
    logic [SRCH_W-1:0]   u_reg, u_next;
    logic [SRCH_W-1:0]   pk_reg, pk_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [ACC_W+DIGIT_W-1:0] part;
    logic [PROD_W-1:0]   part_sh;
    logic [SRCH_W-1:0]   cand;
    logic [SRCH_W-1:0]   rhs;

    assign part = x_reg * y_reg[DIGIT_W-1:0];
    assign cand = s_reg + u_reg + pk_reg;
    assign rhs  = {1'b0, acc_reg, 60'b0};

    always_comb begin
        case (dig_reg)
            2'd0:    part_sh = PROD_W'(part);
            2'd1:    part_sh = PROD_W'(part) << DIGIT_W;
            default: part_sh = PROD_W'(part) << (2 * DIGIT_W);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= COS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
        dig_reg <= dig_next;
        s_reg   <= s_next;
        u_reg   <= u_next;
        pk_reg  <= pk_next;
        bit_reg <= bit_next;
        q_reg   <= q_next;
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        dig_next   = dig_reg;
        s_next     = s_reg;
        u_next     = u_reg;
        pk_next    = pk_reg;
        bit_next   = bit_reg;
        q_next     = q_reg;
        done       = 1'b0;
        case (state_reg)
            COS_IDLE: begin
                if (start) begin
                    x_next     = norm_a;
                    y_next     = norm_b;
                    acc_next   = '0;
                    dig_next   = '0;
                    state_next = COS_MUL_P;
                end
            end
            COS_MUL_P: begin
                acc_next = acc_reg + part_sh;
                y_next   = y_reg >> DIGIT_W;
                dig_next = dig_reg + 2'd1;
                if (dig_reg == 2'd2) begin
                    p_next     = acc_reg + part_sh;
                    x_next     = dot_mag;
                    y_next     = dot_mag;
                    acc_next   = '0;
                    dig_next   = '0;
                    state_next = COS_MUL_D;
                end
            end
            COS_MUL_D: begin
                acc_next = acc_reg + part_sh;
                y_next   = y_reg >> DIGIT_W;
                dig_next = dig_reg + 2'd1;
                if (dig_reg == 2'd2) begin
                    state_next = COS_CHECK;
                end
            end
            COS_CHECK: begin
                s_next   = '0;
                u_next   = '0;
                pk_next  = {1'b0, p_reg, 60'b0} >> 2;
                bit_next = BIT_W'(FRAC_W - 1);
                if (p_reg <= acc_reg) begin
                    q_next     = Q_W'(1) << FRAC_W;
                    state_next = COS_DONE;
                end else begin
                    q_next     = '0;
                    state_next = COS_SEARCH;
                end
            end
            COS_SEARCH: begin
                if (cand <= rhs) begin
                    s_next = cand;
                    u_next = (u_reg >> 1) + pk_reg;
                    q_next = q_reg | (Q_W'(1) << bit_reg);
                end else begin
                    u_next = u_reg >> 1;
                end
                pk_next  = pk_reg >> 2;
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0) begin
                    state_next = COS_DONE;
                end
            end
            COS_DONE: begin
                done       = 1'b1;
                state_next = COS_IDLE;
            end
            default: begin
                state_next = COS_IDLE;
            end
        endcase
    end

    assign q_out = q_reg;

endmodule

[rtl/vector_distance_metric.sv]
// ----------------------------------------------------------------------------
// Vector distance metric
// Streams element groups of two vectors through parallel product lanes, merges
// them into 48-bit accumulators and reports squared L2, negated dot product or
// cosine distance in Q2.30 on the final group of each vector pair.
// ----------------------------------------------------------------------------
// Groups that are not final are taken one per cycle while the block is idle. A
// final group holds off further requests through the merge and final states in
// squared L2 and negated dot mode, and in cosine mode when a norm is zero.
// Otherwise cosine mode holds them off until the cosine unit is done, where a
// shared 48x16 multiplier forms the two products and the root and divide search
// resolves one quotient bit per cycle; when the squared dot magnitude reaches the
// norm product the search is skipped. The result register is freed by the result
// channel before a final group is taken.
module vector_distance_metric
    import vdm_pkg::*;
#(
    parameter int MAX_DIM   = 1024,
    parameter int ELEM_BITS = 16,
    parameter int LANES     = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_a_lane0,
    input  logic signed [IN_W-1:0]  s_a_lane1,
    input  logic signed [IN_W-1:0]  s_a_lane2,
    input  logic signed [IN_W-1:0]  s_a_lane3,
    input  logic signed [IN_W-1:0]  s_b_lane0,
    input  logic signed [IN_W-1:0]  s_b_lane1,
    input  logic signed [IN_W-1:0]  s_b_lane2,
    input  logic signed [IN_W-1:0]  s_b_lane3,
    input  logic [2:0]              s_lanes_valid,
    input  logic                    s_last_group,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ACC_W-1:0] m_distance,
    output logic                    m_zero_norm,
    output logic                    m_overflow
);

    `include "vector_distance_metric_defines.svh"

    localparam int PW    = 2 * ELEM_BITS + 3;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    top_state_t         state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               lane_valid_reg;
    logic               m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]   m_distance_reg, m_distance_next;
    logic               m_zero_norm_reg, m_zero_norm_next;
    logic               m_overflow_reg, m_overflow_next;
    logic               accept;
    logic               load_out;
    logic               cos_start;
    logic               cos_done;
    logic [Q_W-1:0]     cos_q;
    logic [IN_W-1:0]    a_arr [4];
    logic [IN_W-1:0]    b_arr [4];
    logic [2:0]         nl_eff;
    logic [CNT_W-1:0]   remaining;
    logic [2:0]         take;
    logic               drop;
    logic signed [PW-1:0] dot_l [LANES];
    logic signed [PW-1:0] aa_l  [LANES];
    logic signed [PW-1:0] bb_l  [LANES];
    logic signed [PW-1:0] dd_l  [LANES];
    logic [ACC_W-1:0]   dot_acc;
    logic [ACC_W-1:0]   na_acc;
    logic [ACC_W-1:0]   nb_acc;
    logic [ACC_W-1:0]   sq_acc;
    logic [ACC_W-1:0]   dot_mag;

    assign a_arr[0] = s_a_lane0;
    assign a_arr[1] = s_a_lane1;
    assign a_arr[2] = s_a_lane2;
    assign a_arr[3] = s_a_lane3;
    assign b_arr[0] = s_b_lane0;
    assign b_arr[1] = s_b_lane1;
    assign b_arr[2] = s_b_lane2;
    assign b_arr[3] = s_b_lane3;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready || !s_last_group);
    assign accept    = s_valid && s_ready;

    assign nl_eff    = (s_lanes_valid > 3'(LANES)) ? 3'(LANES) : s_lanes_valid;
    assign remaining = CNT_W'(MAX_DIM) - count_reg;
    assign drop      = CNT_W'(nl_eff) > remaining;
    assign take      = drop ? remaining[2:0] : nl_eff;

    generate
        for (genvar i = 0; i < LANES; i++) begin : g_lane
            vdm_lane #(
                .ELEM_BITS(ELEM_BITS)
            ) u_lane (
                .aclk    (aclk),
                .load    (accept),
                .take    (3'(i) < take),
                .a_in    (a_arr[i]),
                .b_in    (b_arr[i]),
                .dot_reg (dot_l[i]),
                .aa_reg  (aa_l[i]),
                .bb_reg  (bb_l[i]),
                .dd_reg  (dd_l[i])
            );
        end
    endgenerate

    vdm_merge #(
        .LANES(LANES),
        .PW   (PW)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .valid      (lane_valid_reg),
        .clear      (load_out),
        .dot_in     (dot_l),
        .aa_in      (aa_l),
        .bb_in      (bb_l),
        .dd_in      (dd_l),
        .dot_reg    (dot_acc),
        .norm_a_reg (na_acc),
        .norm_b_reg (nb_acc),
        .sqdiff_reg (sq_acc)
    );

    assign dot_mag = dot_acc[ACC_W-1] ? (~dot_acc + ACC_W'(1)) : dot_acc;

    vdm_cosine u_cosine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cos_start),
        .dot_mag (dot_mag),
        .norm_a  (na_acc),
        .norm_b  (nb_acc),
        .done    (cos_done),
        .q_out   (cos_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= METRIC_L2;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            lane_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            lane_valid_reg <= accept;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
        m_distance_reg  <= m_distance_next;
        m_zero_norm_reg <= m_zero_norm_next;
        m_overflow_reg  <= m_overflow_next;
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_distance_next  = m_distance_reg;
        m_zero_norm_next = m_zero_norm_reg;
        m_overflow_next  = m_overflow_reg;
        load_out         = 1'b0;
        cos_start        = 1'b0;
        if (accept) begin
            count_next = count_reg + CNT_W'(take);
            ovf_next   = ovf_reg || drop;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_last_group) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                m_zero_norm_next = 1'b0;
                m_overflow_next  = ovf_reg;
                if (mode_reg == METRIC_COS) begin
                    if (na_acc == '0 || nb_acc == '0) begin
                        load_out         = 1'b1;
                        m_distance_next  = Q_ONE;
                        m_zero_norm_next = 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        cos_start  = 1'b1;
                        state_next = ST_COS;
                    end
                end else begin
                    load_out        = 1'b1;
                    m_distance_next = (mode_reg == METRIC_DOT) ? (ACC_W'(0) - dot_acc) : sq_acc;
                    state_next      = ST_IDLE;
                end
            end
            ST_COS: begin
                if (cos_done) begin
                    load_out        = 1'b1;
                    m_distance_next = dot_acc[ACC_W-1] ? (Q_ONE + ACC_W'(cos_q))
                                                       : (Q_ONE - ACC_W'(cos_q));
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out) begin
            m_valid_next = 1'b1;
            count_next   = '0;
            ovf_next     = 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_zero_norm = m_zero_norm_reg;
    assign m_overflow  = m_overflow_reg;

    `VDM_ASSERT_SAME(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_DIM), "count past maximum")
    `VDM_ASSERT_SAME(a_zero_norm_q, m_valid_reg && m_zero_norm_reg, m_distance_reg == Q_ONE, "not one")
    `VDM_ASSERT_NEXT(a_last_busy, accept && s_last_group, !s_ready, "request taken while busy")
    `VDM_ASSERT_SAME(a_cos_owner, cos_done, state_reg == ST_COS, "cosine result unowned")

endmodule

[bench/vdm_checker.sv]
// ----------------------------------------------------------------------------
// Vector distance metric checker
// Watches the configuration, request and result channels. Keeps its own
// accumulators, predicts each result and compares it with what the block sends.
// ----------------------------------------------------------------------------
module vdm_checker
    import vdm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [1:0]              cfg_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_a_lane0,
    input  logic signed [IN_W-1:0]  s_a_lane1,
    input  logic signed [IN_W-1:0]  s_a_lane2,
    input  logic signed [IN_W-1:0]  s_a_lane3,
    input  logic signed [IN_W-1:0]  s_b_lane0,
    input  logic signed [IN_W-1:0]  s_b_lane1,
    input  logic signed [IN_W-1:0]  s_b_lane2,
    input  logic signed [IN_W-1:0]  s_b_lane3,
    input  logic [2:0]              s_lanes_valid,
    input  logic                    s_last_group,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [ACC_W-1:0] m_distance,
    input  logic                    m_zero_norm,
    input  logic                    m_overflow,
    output int                      fail_count,
    output int                      pending
);

    localparam int VEC_LIMIT = 1024;

    typedef struct {
        logic [ACC_W-1:0] distance;
        logic             zero_norm;
        logic             overflow;
    } distance_result_t;

    distance_result_t expected_distances[$];

    logic [1:0]       metric;
    logic [ACC_W-1:0] dot_sum;
    logic [ACC_W-1:0] norm_a_sum;
    logic [ACC_W-1:0] norm_b_sum;
    logic [ACC_W-1:0] sqdiff_sum;
    int               elem_total;
    logic             too_long;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Largest q in 0..2^30 with q^2 * na * nb <= d^2 * 2^60.
    function automatic logic [31:0] cosine_fraction(logic [ACC_W-1:0] d,
                                                    logic [ACC_W-1:0] na,
                                                    logic [ACC_W-1:0] nb);
        logic [159:0] nprod;
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        nprod = 160'(na) * 160'(nb);
        rhs   = (160'(d) * 160'(d)) << 60;
        lo    = 0;
        hi    = 32'h4000_0000;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 160'(mid) * 160'(mid) * nprod;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic signed [IN_W-1:0] a_el[4];
        logic signed [IN_W-1:0] b_el[4];
        longint                 av;
        longint                 bv;
        int                     nl;
        distance_result_t       res;
        logic signed [ACC_W-1:0] dsig;
        logic [ACC_W-1:0]       mag;
        logic [31:0]            q;
        distance_result_t       want;
        if (!aresetn) begin
            metric     = METRIC_L2;
            dot_sum    = '0;
            norm_a_sum = '0;
            norm_b_sum = '0;
            sqdiff_sum = '0;
            elem_total = 0;
            too_long   = 1'b0;
            expected_distances.delete();
        end else begin
            if (cfg_valid && cfg_ready) metric = cfg_data;

            if (s_valid && s_ready) begin
                a_el = '{s_a_lane0, s_a_lane1, s_a_lane2, s_a_lane3};
                b_el = '{s_b_lane0, s_b_lane1, s_b_lane2, s_b_lane3};
                nl = (s_lanes_valid > 4) ? 4 : s_lanes_valid;
                for (int i = 0; i < nl; i++) begin
                    if (elem_total >= VEC_LIMIT) begin
                        too_long = 1'b1;
                    end else begin
                        av = a_el[i];
                        bv = b_el[i];
                        elem_total++;
                        dot_sum    = dot_sum + ACC_W'(av * bv);
                        norm_a_sum = norm_a_sum + ACC_W'(av * av);
                        norm_b_sum = norm_b_sum + ACC_W'(bv * bv);
                        sqdiff_sum = sqdiff_sum + ACC_W'((av - bv) * (av - bv));
                    end
                end
                if (s_last_group) begin
                    res.zero_norm = 1'b0;
                    if (metric == METRIC_COS) begin
                        if (norm_a_sum == 0 || norm_b_sum == 0) begin
                            res.distance  = Q_ONE;
                            res.zero_norm = 1'b1;
                        end else begin
                            dsig = dot_sum;
                            mag  = dsig < 0 ? -dot_sum : dot_sum;
                            q    = cosine_fraction(mag, norm_a_sum, norm_b_sum);
                            res.distance = dsig < 0 ? Q_ONE + ACC_W'(q) : Q_ONE - ACC_W'(q);
                        end
                    end else if (metric == METRIC_DOT) begin
                        res.distance = -dot_sum;
                    end else begin
                        res.distance = sqdiff_sum;
                    end
                    res.overflow = too_long;
                    expected_distances.push_back(res);
                    dot_sum    = '0;
                    norm_a_sum = '0;
                    norm_b_sum = '0;
                    sqdiff_sum = '0;
                    elem_total = 0;
                    too_long   = 1'b0;
                end
            end

            if (m_valid && m_ready) begin
                if (expected_distances.size() == 0) begin
                    report_mismatch($sformatf("unexpected result distance %0d", m_distance));
                end else begin
                    want = expected_distances.pop_front();
                    if (m_distance !== want.distance)
                        report_mismatch($sformatf("distance %0h, expected %0h",
                                                  m_distance, want.distance));
                    if (m_zero_norm !== want.zero_norm)
                        report_mismatch($sformatf("zero_norm %b, expected %b",
                                                  m_zero_norm, want.zero_norm));
                    if (m_overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  m_overflow, want.overflow));
                end
            end
        end
        pending = expected_distances.size();
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Vector distance metric testbench
// Streams directed and random vector pairs under every metric setting, with
// random idling on both channels and a long result stall, and lets the checker
// compare every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vdm_pkg::*;

    localparam logic [1:0] METRIC_SPARE = 2'd3;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_a_lane0, s_a_lane1, s_a_lane2, s_a_lane3;
    logic signed [IN_W-1:0]  s_b_lane0, s_b_lane1, s_b_lane2, s_b_lane3;
    logic [2:0]              s_lanes_valid;
    logic                    s_last_group;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [ACC_W-1:0] m_distance;
    logic                    m_zero_norm;
    logic                    m_overflow;
    int                      fail_count;
    int                      pending;
    int                      tx_idle_pct;
    int                      rx_idle_pct;
    logic                    hold_results;
    logic                    start_hold;

    vector_distance_metric dut (.*);

    vdm_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
    end

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        m_ready      = 1'b0;
        hold_results = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= !hold_results && ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (start_hold);
        @(posedge aclk);
        hold_results <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_results <= 1'b0;
    end

    initial begin
        #6000000;
        $display("vector_distance_metric: mismatch");
        $finish;
    end

    task automatic write_metric(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_group(input logic signed [15:0] a[4], input logic signed [15:0] b[4],
                              input logic [2:0] lanes, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_a_lane0     <= a[0];
        s_a_lane1     <= a[1];
        s_a_lane2     <= a[2];
        s_a_lane3     <= a[3];
        s_b_lane0     <= b[0];
        s_b_lane1     <= b[1];
        s_b_lane2     <= b[2];
        s_b_lane3     <= b[3];
        s_lanes_valid <= lanes;
        s_last_group  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_vector(input int groups, input int style);
        logic signed [15:0] a[4];
        logic signed [15:0] b[4];
        logic [2:0]         lanes;
        for (int g = 0; g < groups; g++) begin
            for (int i = 0; i < 4; i++) begin
                a[i] = 16'($urandom());
                case (style)
                    1: b[i] = a[i];
                    2: b[i] = -a[i];
                    3: begin
                        a[i] = 16'($urandom_range(0, 6)) - 16'sd3;
                        b[i] = 16'($urandom_range(0, 6)) - 16'sd3;
                    end
                    default: b[i] = 16'($urandom());
                endcase
            end
            lanes = ($urandom_range(3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_group(a, b, lanes, g == groups - 1);
        end
    endtask

    task automatic directed_groups();
        logic signed [15:0] lo[4];
        logic signed [15:0] hi[4];
        logic signed [15:0] zz[4];
        logic signed [15:0] mx[4];
        lo = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        hi = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        zz = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        mx = '{16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
        write_metric(METRIC_L2);
        send_group(lo, hi, 3'd4, 1'b1);
        send_group(lo, lo, 3'd7, 1'b0);
        send_group(mx, lo, 3'd2, 1'b1);
        drain_results();
        write_metric(METRIC_COS);
        send_group(zz, hi, 3'd4, 1'b1);
        send_group(hi, zz, 3'd4, 1'b1);
        send_group(lo, hi, 3'd4, 1'b1);
        send_group(hi, hi, 3'd4, 1'b1);
        send_group(mx, mx, 3'd0, 1'b1);
        send_group(mx, hi, 3'd5, 1'b1);
        drain_results();
        write_metric(METRIC_DOT);
        send_group(lo, lo, 3'd4, 1'b0);
        send_group(lo, lo, 3'd4, 1'b1);
        send_group(lo, hi, 3'd6, 1'b1);
        drain_results();
        write_metric(METRIC_SPARE);
        send_group(lo, hi, 3'd4, 1'b1);
        send_group(mx, zz, 3'd1, 1'b1);
        drain_results();
    endtask

    initial begin
        logic [1:0] modes[4];
        int         sent;
        int         groups;
        modes         = '{METRIC_L2, METRIC_COS, METRIC_DOT, METRIC_SPARE};
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_a_lane0     = '0;
        s_a_lane1     = '0;
        s_a_lane2     = '0;
        s_a_lane3     = '0;
        s_b_lane0     = '0;
        s_b_lane1     = '0;
        s_b_lane2     = '0;
        s_b_lane3     = '0;
        s_lanes_valid = '0;
        s_last_group  = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        start_hold    = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_groups();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 71 : 0;
            rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 37 : 0;
            for (int m = 0; m < 4; m++) begin
                drain_results();
                write_metric(modes[m]);
                if (phase == 2 && m == 0) start_hold = 1'b1;
                if ((phase == 0 && m == 1) || (phase == 2 && m == 0)) send_vector(300, 0);
                sent = 0;
                while (sent < 36) begin
                    groups = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 6);
                    send_vector(groups, $urandom_range(0, 3));
                    sent += groups;
                end
            end
        end
        s_valid <= 1'b0;
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("vector_distance_metric: match");
        end else begin
            $display("vector_distance_metric: mismatch");
        end
        $finish;
    end

endmodule
